// ----- rtl/fkv_pkg.sv -----
// Package for the fixed-capacity key/value table.
// Holds the request and response payload types, the operation codes, the controller
// state type and the command/status structs shared by the controller and the datapath.
package fkv_pkg;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 64;

    localparam int TYPE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [KEY_W-1:0]   req_key;
        logic [VALUE_W-1:0] req_value;
        logic [INDEX_W-1:0] req_index;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key_out;
        logic [VALUE_W-1:0] value_out;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp;

    typedef enum logic [TYPE_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_UPSERT  = 3'd2,
        OP_ERASE   = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_READ_AT = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_CMP,
        S_MISS,
        S_RDX,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    // Read address source.
    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX1,
        RD_REQ_INDEX
    } t_rd_sel;

    // Write address source.
    typedef enum logic {
        WA_IDX,
        WA_CNT
    } t_wa_sel;

    // Write data source.
    typedef enum logic {
        WD_REQ,
        WD_SHIFT
    } t_wd_sel;

    typedef struct packed {
        logic    req_ready;
        logic    load_req;
        logic    inc_idx;
        t_rd_sel rd_sel;
        logic    key_we;
        logic    val_we;
        t_wa_sel wa_sel;
        t_wd_sel wd_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_ok;
        logic    res_key;
        logic    res_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_lt_cnt;
        logic idx1_lt_cnt;
        logic index_ok;
        logic key_hit;
        logic full;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/fkv_ctrl.sv -----
// Controller state machine for the key/value table.
// Depends on fkv_pkg; drives the datapath through t_cmd and reads back t_sts.
module fkv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  fkv_pkg::t_sts i_sts,
    output fkv_pkg::t_cmd o_cmd
);
    import fkv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                unique case (i_sts.op)
                    OP_READ_AT: n_state = i_sts.index_ok ? S_RDX : S_DONE;
                    OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP: begin
                        n_state = i_sts.idx_lt_cnt ? S_SCAN : S_MISS;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: n_state = S_CMP;
            S_CMP: begin
                if (i_sts.key_hit) begin
                    n_state = (i_sts.op == OP_ERASE) ? S_SH_RD : S_DONE;
                end else begin
                    n_state = i_sts.idx1_lt_cnt ? S_SCAN : S_MISS;
                end
            end
            S_MISS: n_state = S_DONE;
            S_RDX:  n_state = S_DONE;
            S_SH_RD: n_state = i_sts.idx1_lt_cnt ? S_SH_WR : S_DONE;
            S_SH_WR: n_state = S_SH_RD;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = RD_IDX;
        o_cmd.wa_sel = WA_IDX;
        o_cmd.wd_sel = WD_REQ;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.req_ready = 1'b1;
                o_cmd.load_req  = i_req_valid;
            end
            S_START: begin
                o_cmd.rd_sel = RD_REQ_INDEX;
            end
            S_SCAN: begin
                o_cmd.rd_sel = RD_IDX;
            end
            S_CMP: begin
                if (i_sts.key_hit) begin
                    unique case (i_sts.op)
                        OP_UPDATE, OP_UPSERT: begin
                            o_cmd.val_we = 1'b1;
                            o_cmd.res_ok = 1'b1;
                        end
                        OP_LOOKUP: begin
                            o_cmd.res_val = 1'b1;
                            o_cmd.res_ok  = 1'b1;
                        end
                        default: ;
                    endcase
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_MISS: begin
                // Absent key: only insert and upsert append, and only with room left.
                if ((i_sts.op == OP_INSERT || i_sts.op == OP_UPSERT) && !i_sts.full) begin
                    o_cmd.key_we  = 1'b1;
                    o_cmd.val_we  = 1'b1;
                    o_cmd.wa_sel  = WA_CNT;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.res_ok  = 1'b1;
                end
            end
            S_RDX: begin
                o_cmd.res_key = 1'b1;
                o_cmd.res_val = 1'b1;
                o_cmd.res_ok  = 1'b1;
            end
            S_SH_RD: begin
                if (i_sts.idx1_lt_cnt) begin
                    o_cmd.rd_sel = RD_IDX1;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.res_ok  = 1'b1;
                end
            end
            S_SH_WR: begin
                o_cmd.key_we  = 1'b1;
                o_cmd.val_we  = 1'b1;
                o_cmd.wd_sel  = WD_SHIFT;
                o_cmd.inc_idx = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/fkv_datapath.sv -----
// Datapath for the key/value table: key and value memories, entry count, scan index,
// request and result registers and the response output register.
// Depends on fkv_pkg; controlled by fkv_ctrl through t_cmd.
module fkv_datapath #(
    parameter int CAPACITY   = fkv_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = fkv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = fkv_pkg::DEF_VALUE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fkv_pkg::t_req i_req,
    input  fkv_pkg::t_cmd i_cmd,
    output fkv_pkg::t_sts o_sts,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output fkv_pkg::t_rsp o_rsp
);
    import fkv_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0]   key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];

    logic [TYPE_W-1:0]     r_req_type;
    logic [KEY_BITS-1:0]   r_req_key;
    logic [VALUE_BITS-1:0] r_req_value;
    logic [INDEX_W-1:0]    r_req_index;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         w_idx1;

    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    logic                  r_res_ok;
    logic [KEY_BITS-1:0]   r_res_key;
    logic [VALUE_BITS-1:0] r_res_val;

    logic                  r_rsp_valid;
    t_rsp                  r_rsp;

    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [KEY_BITS-1:0]   w_wr_key;
    logic [VALUE_BITS-1:0] w_wr_val;

    assign w_idx1 = r_idx + CW'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_IDX:       w_rd_addr = r_idx[AW-1:0];
            RD_IDX1:      w_rd_addr = w_idx1[AW-1:0];
            RD_REQ_INDEX: w_rd_addr = AW'(r_req_index);
            default:      w_rd_addr = r_idx[AW-1:0];
        endcase
    end

    assign w_wr_addr = (i_cmd.wa_sel == WA_CNT) ? r_count[AW-1:0] : r_idx[AW-1:0];
    assign w_wr_key  = (i_cmd.wd_sel == WD_SHIFT) ? r_rd_key : r_req_key;
    assign w_wr_val  = (i_cmd.wd_sel == WD_SHIFT) ? r_rd_val : r_req_value;

    // One write and one registered read per memory each cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            key_mem[w_wr_addr] <= w_wr_key;
        end
        r_rd_key <= key_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.val_we) begin
            val_mem[w_wr_addr] <= w_wr_val;
        end
        r_rd_val <= val_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type  <= i_req.req_type;
            r_req_key   <= KEY_BITS'(i_req.req_key);
            r_req_value <= VALUE_BITS'(i_req.req_value);
            r_req_index <= i_req.req_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= w_idx1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_res_ok  <= 1'b0;
            r_res_key <= '0;
            r_res_val <= '0;
        end else begin
            if (i_cmd.res_ok) begin
                r_res_ok <= 1'b1;
            end
            if (i_cmd.res_key) begin
                r_res_key <= r_rd_key;
            end
            if (i_cmd.res_val) begin
                r_res_val <= r_rd_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.ok          <= r_res_ok;
            r_rsp.key_out     <= KEY_W'(r_res_key);
            r_rsp.value_out   <= VALUE_W'(r_res_val);
            r_rsp.entry_count <= COUNT_W'(r_count);
        end
    end

    assign o_sts.op          = t_op'(r_req_type);
    assign o_sts.idx_lt_cnt  = (r_idx < r_count);
    assign o_sts.idx1_lt_cnt = (w_idx1 < r_count);
    assign o_sts.index_ok    = (32'(r_req_index) < 32'(r_count))
                            && (32'(r_req_index) < 32'(CAPACITY));
    assign o_sts.key_hit     = (r_rd_key == r_req_key);
    assign o_sts.full        = (r_count >= CW'(CAPACITY));
    assign o_sts.out_free    = !r_rsp_valid || i_rsp_ready;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- rtl/fixed_capacity_key_value_table.sv -----
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------------------
// request   | i_req_valid / o_req_ready  | i_req (type, key, value, index)
// response  | o_rsp_valid / i_rsp_ready  | o_rsp (ok, key_out, value_out, count)
//
// One request is worked on at a time. A key search reads one entry at a time through
// the registered memory read port, in a scan and a compare state per stored pair;
// erase then moves each later pair down one place, through a read and a write state.
// Read at index reads the indexed entry. The response register lets the next request
// be taken while the previous response still waits; a full response register stalls
// completion. Synchronous active-low reset clears the count; memories are not cleared.
//
// Top level of the fixed-capacity key/value table; depends on fkv_pkg, fkv_ctrl and
// fkv_datapath.
module fixed_capacity_key_value_table #(
    parameter int CAPACITY   = fkv_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = fkv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = fkv_pkg::DEF_VALUE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  fkv_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output fkv_pkg::t_rsp o_rsp
);
    import fkv_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    fkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fkv_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    assign o_req_ready = w_cmd.req_ready;

endmodule

// ----- rtl/fkv_checker.sv -----
// Port-level checks for the key/value table, attached to the top level by bind.
// Depends on fkv_pkg and on the ports of fixed_capacity_key_value_table.
module fkv_checker #(
    parameter int CAPACITY = fkv_pkg::DEF_CAPACITY
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_ready,
    input fkv_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input fkv_pkg::t_rsp o_rsp
);
    import fkv_pkg::*;

    // The table never reports more pairs than it can hold.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (32'(o_rsp.entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    // A failed request returns neither key nor value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.ok) |-> (o_rsp.key_out == '0 && o_rsp.value_out == '0))
        else $error("failed response carries data");

    // The block is busy in the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while busy");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed");

endmodule

bind fixed_capacity_key_value_table fkv_checker #(.CAPACITY(CAPACITY)) u_fkv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

// ----- tb/sv/tb_fixed_capacity_key_value_table.sv -----
// Self-checking testbench for fixed_capacity_key_value_table: directed, fill-to-capacity and
// random request traffic, with every response checked against a table kept in the bench.
// Depends on fkv_pkg and the fixed_capacity_key_value_table RTL.
`timescale 1ns / 1ps

module tb_fixed_capacity_key_value_table;
    import fkv_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = 1200;
    localparam logic [TYPE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [TYPE_W-1:0] OP_UNUSED_7 = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    // The bench's own copy of the table.
    logic [KEY_W-1:0]   kv_keys [CAPACITY];
    logic [VALUE_W-1:0] kv_vals [CAPACITY];
    int                 kv_count;

    t_rsp expected_rsp_q [$];
    int   mismatch_count = 0;
    int   watchdog_cycles = 0;
    int   stall_left = 0;
    bit   sender_idles = 1'b1;
    bit   receiver_idles = 1'b1;
    int   op_seen [8];
    int   ok_count = 0;
    int   peak_count = 0;

    fixed_capacity_key_value_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int find_position(input logic [KEY_W-1:0] key);
        int i;
        for (i = 0; i < kv_count; i++) begin
            if (kv_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_req make_request(input logic [TYPE_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [INDEX_W-1:0] index);
        t_req r;
        r.req_type  = op;
        r.req_key   = key;
        r.req_value = value;
        r.req_index = index;
        return r;
    endfunction

    // Applies one request to the bench table and returns the response it must produce.
    function automatic t_rsp predict_table_response(input t_req r);
        t_rsp rsp;
        int   pos;
        int   j;
        rsp = '0;
        pos = find_position(r.req_key);
        case (r.req_type)
            OP_INSERT: begin
                if (pos < 0 && kv_count < CAPACITY) begin
                    kv_keys[kv_count] = r.req_key;
                    kv_vals[kv_count] = r.req_value;
                    kv_count++;
                    rsp.ok = 1'b1;
                end
            end
            OP_UPDATE: begin
                if (pos >= 0) begin
                    kv_vals[pos] = r.req_value;
                    rsp.ok = 1'b1;
                end
            end
            OP_UPSERT: begin
                if (pos >= 0) begin
                    kv_vals[pos] = r.req_value;
                    rsp.ok = 1'b1;
                end else if (kv_count < CAPACITY) begin
                    kv_keys[kv_count] = r.req_key;
                    kv_vals[kv_count] = r.req_value;
                    kv_count++;
                    rsp.ok = 1'b1;
                end
            end
            OP_ERASE: begin
                if (pos >= 0) begin
                    for (j = pos; j + 1 < kv_count; j++) begin
                        kv_keys[j] = kv_keys[j + 1];
                        kv_vals[j] = kv_vals[j + 1];
                    end
                    kv_count--;
                    rsp.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (pos >= 0) begin
                    rsp.value_out = kv_vals[pos];
                    rsp.ok = 1'b1;
                end
            end
            OP_READ_AT: begin
                if (int'(r.req_index) < kv_count) begin
                    rsp.key_out   = kv_keys[r.req_index];
                    rsp.value_out = kv_vals[r.req_index];
                    rsp.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        rsp.entry_count = kv_count[COUNT_W-1:0];
        return rsp;
    endfunction

    // Presents one request and waits for it to be taken. Valid is left high on return so
    // that back-to-back requests need no second assignment in the same time step.
    task automatic send_request(input t_req r);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        expected_rsp_q.push_back(predict_table_response(r));
        op_seen[r.req_type]++;
        if (kv_count > peak_count) begin
            peak_count = kv_count;
        end
    endtask

    task automatic await_all_responses();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (expected_rsp_q.size() != 0);
    endtask

    task automatic test_directed();
        logic [KEY_W-1:0]   key_max;
        logic [VALUE_W-1:0] val_max;
        key_max = '1;
        val_max = '1;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        // Empty table: every search misses and every index is out of range.
        send_request(make_request(OP_LOOKUP, '0, val_max, '0));
        send_request(make_request(OP_READ_AT, key_max, '0, '0));
        send_request(make_request(OP_READ_AT, '0, '0, '1));
        send_request(make_request(OP_ERASE, key_max, '0, '0));
        send_request(make_request(OP_UPDATE, '0, val_max, '0));
        send_request(make_request(OP_INSERT, '0, '0, '0));
        send_request(make_request(OP_INSERT, key_max, val_max, '1));
        send_request(make_request(OP_INSERT, '0, val_max, '0));
        send_request(make_request(OP_UPSERT, 32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, '0));
        send_request(make_request(OP_UPSERT, '0, 64'hFEDC_BA98_7654_3210, '0));
        send_request(make_request(OP_UPDATE, key_max, 64'h5555_AAAA_5555_AAAA, '0));
        send_request(make_request(OP_LOOKUP, key_max, '0, '0));
        send_request(make_request(OP_LOOKUP, '0, '0, '0));
        send_request(make_request(OP_READ_AT, '0, '0, 8'd0));
        send_request(make_request(OP_READ_AT, '0, '0, 8'd2));
        send_request(make_request(OP_READ_AT, '0, '0, 8'd3));
        send_request(make_request(OP_READ_AT, '0, '0, '1));
        send_request(make_request(OP_UNUSED_6, key_max, val_max, '1));
        send_request(make_request(OP_UNUSED_7, '0, val_max, 8'd0));
        // Erasing the first pair moves the later ones down; erasing the last moves none.
        send_request(make_request(OP_ERASE, '0, '0, '0));
        send_request(make_request(OP_READ_AT, '0, '0, 8'd0));
        send_request(make_request(OP_ERASE, 32'hA5A5_5A5A, '0, '0));
        send_request(make_request(OP_LOOKUP, 32'hA5A5_5A5A, '0, '0));
        send_request(make_request(OP_ERASE, key_max, '0, '0));
        send_request(make_request(OP_INSERT, '0, val_max, '0));
    endtask

    task automatic test_fill_to_capacity();
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] held_key;
        // A stretch with no idling on either side while the table fills.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        while (kv_count < CAPACITY) begin
            key = $urandom;
            if (find_position(key) < 0) begin
                send_request(make_request(OP_INSERT, key, {$urandom, $urandom}, '0));
            end
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        held_key = kv_keys[$urandom_range(0, CAPACITY - 1)];
        do key = $urandom; while (find_position(key) >= 0);
        send_request(make_request(OP_INSERT, key, {$urandom, $urandom}, '0));
        send_request(make_request(OP_UPSERT, key, {$urandom, $urandom}, '0));
        send_request(make_request(OP_INSERT, held_key, {$urandom, $urandom}, '0));
        send_request(make_request(OP_UPSERT, held_key, {$urandom, $urandom}, '0));
        send_request(make_request(OP_UPDATE, kv_keys[CAPACITY - 1], '1, '0));
        send_request(make_request(OP_READ_AT, '0, '0, '1));
        send_request(make_request(OP_LOOKUP, kv_keys[CAPACITY - 1], '0, '0));
        send_request(make_request(OP_LOOKUP, key, '0, '0));
        // Hold off until the full table has answered everything.
        await_all_responses();
    endtask

    task automatic test_random_traffic(input int n_items, input int erase_pct);
        int                 n;
        int                 roll;
        int                 hit_pct;
        logic [TYPE_W-1:0]  op;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
        for (n = 0; n < n_items; n++) begin
            sender_idles   = ((n / 40) % 3) != 2;
            receiver_idles = ((n / 40) % 4) != 3;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
            end else if (roll < 3 + erase_pct) begin
                op = OP_ERASE;
            end else begin
                case ($urandom_range(0, 4))
                    0: op = OP_INSERT;
                    1: op = OP_UPDATE;
                    2: op = OP_UPSERT;
                    3: op = OP_LOOKUP;
                    default: op = OP_READ_AT;
                endcase
            end
            hit_pct = (op == OP_INSERT) ? 25 : (op == OP_ERASE) ? 90 : 75;
            if (kv_count > 0 && $urandom_range(0, 99) < hit_pct) begin
                key = kv_keys[$urandom_range(0, kv_count - 1)];
            end else begin
                key = $urandom;
            end
            if (kv_count > 0 && $urandom_range(0, 3) != 0) begin
                index = INDEX_W'($urandom_range(0, kv_count - 1));
            end else begin
                index = INDEX_W'($urandom_range(0, 255));
            end
            send_request(make_request(op, key, {$urandom, $urandom}, index));
        end
    endtask

    // Response side: a fresh stall is drawn after every response taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            stall_left  <= 0;
        end else if (o_rsp_valid && i_rsp_ready) begin : draw_stall
            int d;
            d = receiver_idles ? $urandom_range(0, 8) : 0;
            stall_left  <= d;
            i_rsp_ready <= (d == 0);
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_rsp_ready <= (stall_left == 1);
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_response
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("response with no request outstanding: %h", o_rsp);
                mismatch_count++;
            end else begin
                want = expected_rsp_q.pop_front();
                if (want.ok) begin
                    ok_count++;
                end
                if (o_rsp.ok !== want.ok) begin
                    $error("ok mismatch: expected %0d, got %0d", want.ok, o_rsp.ok);
                    mismatch_count++;
                end
                if (o_rsp.key_out !== want.key_out) begin
                    $error("key_out mismatch: expected %h, got %h", want.key_out, o_rsp.key_out);
                    mismatch_count++;
                end
                if (o_rsp.value_out !== want.value_out) begin
                    $error("value_out mismatch: expected %h, got %h",
                           want.value_out, o_rsp.value_out);
                    mismatch_count++;
                end
                if (o_rsp.entry_count !== want.entry_count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           want.entry_count, o_rsp.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            watchdog_cycles <= 0;
        end else if (watchdog_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog expired after %0d idle cycles", watchdog_cycles);
            $display("fixed_capacity_key_value_table regression: fail");
            $finish;
        end else begin
            watchdog_cycles <= watchdog_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        kv_count = 0;
        foreach (op_seen[i]) begin
            op_seen[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_to_capacity();
        test_random_traffic(250, 25);
        test_random_traffic(350, 75);
        test_random_traffic(60, 25);

        await_all_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_rsp_q.size() != 0) begin
            $error("%0d responses never arrived", expected_rsp_q.size());
            mismatch_count++;
        end
        $write("Requests: insert %0d, update %0d, upsert %0d, erase %0d, ",
               op_seen[OP_INSERT], op_seen[OP_UPDATE], op_seen[OP_UPSERT], op_seen[OP_ERASE]);
        $display("lookup %0d, read-at %0d, unused %0d", op_seen[OP_LOOKUP], op_seen[OP_READ_AT],
                 op_seen[OP_UNUSED_6] + op_seen[OP_UNUSED_7]);
        $display("%0d requests succeeded; occupancy peaked at %0d of %0d entries",
                 ok_count, peak_count, CAPACITY);
        if (mismatch_count == 0) begin
            $display("fixed_capacity_key_value_table regression: pass");
        end else begin
            $display("fixed_capacity_key_value_table regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fkv_pkg.sv
rtl/fkv_ctrl.sv
rtl/fkv_datapath.sv
rtl/fixed_capacity_key_value_table.sv
rtl/fkv_checker.sv
tb/sv/tb_fixed_capacity_key_value_table.sv
